// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: invariant violated");

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// Checks that a condition implies a consequence in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check violated");

`endif

// File: rtl/tawr_pkg.sv
package tawr_pkg;

    // Index width and the restart codes.
    localparam int unsigned IDX_W = 32;
    localparam logic [IDX_W-1:0] NARROW_MASK    = 32'h0000_FFFF;
    localparam logic [IDX_W-1:0] RESTART_NARROW = 32'h0000_FFFF;
    localparam logic [IDX_W-1:0] RESTART_WIDE   = 32'hFFFF_FFFF;

    // Queue between the front and the back.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Result buffer at the output.
    localparam int unsigned OUT_DEPTH = 2;
    localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Configuration register indexes.
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_WIDE_INDICES   = 1'b0;
    localparam t_cfg_idx CFG_PRIMITIVE_MODE = 1'b1;

    // Number of valid entries in the two-entry window.
    typedef enum logic [1:0] {
        FILL_EMPTY,
        FILL_ONE,
        FILL_TWO
    } t_fill;

    // One classified index as it travels from the front to the back.
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             restart;
        logic             last;
        logic             strip;
    } t_item;

    // One result as it leaves the block.
    typedef struct packed {
        logic [IDX_W-1:0] corner_a;
        logic [IDX_W-1:0] corner_b;
        logic [IDX_W-1:0] corner_c;
        logic             tri_valid;
        logic             done;
    } t_result;

    // Occupancy flags of the middle queue.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

// File: rtl/tawr_front.sv
module tawr_front
    import tawr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_index,
    input  logic             i_cfg_wdata,
    input  logic [IDX_W-1:0] i_vertex_index,
    input  logic             i_stream_end,
    output t_item            o_item
);

    logic r_wide;
    logic r_strip;
    logic n_wide;
    logic n_strip;
    logic [IDX_W-1:0] w_masked;

    // Configuration register writes.
    always_comb begin
        n_wide  = r_wide;
        n_strip = r_strip;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDE_INDICES:   n_wide  = i_cfg_wdata;
                CFG_PRIMITIVE_MODE: n_strip = i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide  <= 1'b0;
            r_strip <= 1'b0;
        end else begin
            r_wide  <= n_wide;
            r_strip <= n_strip;
        end
    end

    // Mask narrow indices and detect the restart code.
    assign w_masked = r_wide ? i_vertex_index : (i_vertex_index & NARROW_MASK);

    always_comb begin
        o_item.index   = w_masked;
        o_item.restart = (w_masked == RESTART_NARROW) ||
                         (r_wide && (w_masked == RESTART_WIDE));
        o_item.last    = i_stream_end;
        o_item.strip   = r_strip;
    end

endmodule

// File: rtl/tawr_queue.sv
`include "assert_macros.svh"

module tawr_queue
    import tawr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_head,
    output t_q_status o_status
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic [Q_CNT_W-1:0] n_cnt;
    logic               w_wr;
    logic               w_rd;

    // Occupancy flags and qualified transactions.
    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign w_wr = i_push && !o_status.full;
    assign w_rd = i_pop && !o_status.empty;
    assign o_head = r_mem[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Pointer and count registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `ASSERT_ALWAYS(a_q_no_overflow, i_clk, i_rst_n, r_cnt <= Q_CNT_W'(Q_DEPTH))
    `ASSERT_NEXT(a_q_drain, i_clk, i_rst_n, w_rd && !w_wr, r_cnt == $past(r_cnt) - 1'b1)

endmodule

// File: rtl/tawr_back.sv
`include "assert_macros.svh"

module tawr_back
    import tawr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_item     i_head,
    input  t_q_status i_q_status,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_result   o_result
);

    logic [IDX_W-1:0]     r_older;
    logic [IDX_W-1:0]     r_newer;
    t_fill                r_fill;
    logic                 r_parity;
    logic [IDX_W-1:0]     n_older;
    logic [IDX_W-1:0]     n_newer;
    t_fill                n_fill;
    logic                 n_parity;

    t_result              r_out [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_out_wr;
    logic [OUT_PTR_W-1:0] r_out_rd;
    logic [OUT_CNT_W-1:0] r_out_cnt;
    logic [OUT_CNT_W-1:0] n_out_cnt;

    logic                 w_out_rd;
    logic                 w_take;
    logic                 w_made;
    logic                 w_out_wr;
    t_result              w_res;

    // Result buffer read side.
    assign o_empty  = (r_out_cnt == '0);
    assign o_result = r_out[r_out_rd];
    assign w_out_rd = i_pop && !o_empty;

    // Take the next item when the result buffer has room this cycle.
    assign w_take  = !i_q_status.empty &&
                     ((r_out_cnt != OUT_CNT_W'(OUT_DEPTH)) || w_out_rd);
    assign o_q_pop = w_take;

    // Window update and triangle formation for the item at the queue head.
    always_comb begin
        n_older  = r_older;
        n_newer  = r_newer;
        n_fill   = r_fill;
        n_parity = r_parity;
        w_made   = 1'b0;
        w_res    = '0;
        if (i_head.restart) begin
            n_fill   = FILL_EMPTY;
            n_parity = 1'b0;
        end else begin
            case (r_fill)
                FILL_TWO: begin
                    w_made         = 1'b1;
                    w_res.corner_c = i_head.index;
                    if (i_head.strip && r_parity) begin
                        w_res.corner_a = r_newer;
                        w_res.corner_b = r_older;
                    end else begin
                        w_res.corner_a = r_older;
                        w_res.corner_b = r_newer;
                    end
                    if (i_head.strip) begin
                        n_older  = r_newer;
                        n_newer  = i_head.index;
                        n_parity = !r_parity;
                    end else begin
                        n_fill   = FILL_EMPTY;
                        n_parity = 1'b0;
                    end
                end
                FILL_ONE: begin
                    n_newer = i_head.index;
                    n_fill  = FILL_TWO;
                end
                default: begin
                    n_older = i_head.index;
                    n_fill  = FILL_ONE;
                end
            endcase
        end
        // The end of a draw empties the window and clears the strip parity.
        if (i_head.last) begin
            n_fill   = FILL_EMPTY;
            n_parity = 1'b0;
        end
        w_res.tri_valid = w_made;
        w_res.done      = i_head.last;
    end

    assign w_out_wr = w_take && (w_made || i_head.last);

    always_comb begin
        n_out_cnt = r_out_cnt;
        if (w_out_wr && !w_out_rd) begin
            n_out_cnt = r_out_cnt + 1'b1;
        end else if (w_out_rd && !w_out_wr) begin
            n_out_cnt = r_out_cnt - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= FILL_EMPTY;
            r_parity  <= 1'b0;
            r_out_wr  <= '0;
            r_out_rd  <= '0;
            r_out_cnt <= '0;
        end else begin
            r_out_cnt <= n_out_cnt;
            if (w_take) begin
                r_fill   <= n_fill;
                r_parity <= n_parity;
            end
            if (w_out_wr) begin
                r_out_wr <= r_out_wr + 1'b1;
            end
            if (w_out_rd) begin
                r_out_rd <= r_out_rd + 1'b1;
            end
        end
    end

    // Window and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_older <= n_older;
            r_newer <= n_newer;
        end
        if (w_out_wr) begin
            r_out[r_out_wr] <= w_res;
        end
    end

    `ASSERT_IMPLIES(a_parity_needs_full_window, i_clk, i_rst_n, r_parity, r_fill == FILL_TWO)
    `ASSERT_IMPLIES(a_empty_result_ends_draw, i_clk, i_rst_n, w_out_wr && !w_res.tri_valid, w_res.done)

endmodule

// File: rtl/triangle_assembler_with_restart.sv
// Triangle assembler with primitive restart.
// Input channel: one vertex index per transaction on i_vertex_index with
// i_stream_end marking the last index of a draw; a transaction completes
// when push is high and full is low.
// Result channel: corners, triangle flag and draw-done flag of the oldest
// result are on the output ports while empty is low; pop takes it.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_index
// (0: wide indices, 1: strip mode) at the clock edge; write only when idle.
// Throughput is one index per cycle while the result buffer has room: the
// back end retires one queued index per cycle with a single window update.
// An accepted index is written into the four-entry middle queue, and any
// result it makes into the two-entry result buffer that drives the ports.
// When the receiver stalls, the result buffer and then the middle queue
// fill, and full rises once two results are buffered and four indices queued.
// Synchronous reset clears both registers to zero, empties the window,
// the strip parity and both queues.
module triangle_assembler_with_restart
    import tawr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_index,
    input  logic             i_cfg_wdata,
    input  logic             push,
    output logic             full,
    input  logic [IDX_W-1:0] i_vertex_index,
    input  logic             i_stream_end,
    output logic             empty,
    input  logic             pop,
    output logic [IDX_W-1:0] o_corner_a,
    output logic [IDX_W-1:0] o_corner_b,
    output logic [IDX_W-1:0] o_corner_c,
    output logic             o_triangle_valid,
    output logic             o_draw_done
);

    t_item     w_item;
    t_item     w_head;
    t_q_status w_q_status;
    logic      w_q_pop;
    t_result   w_result;

    // Front end: configuration and index classification.
    tawr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_vertex_index (i_vertex_index),
        .i_stream_end   (i_stream_end),
        .o_item         (w_item)
    );

    // Decoupling queue between front and back.
    tawr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (w_item),
        .i_pop    (w_q_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // Back end: window, triangle assembly and result buffer.
    tawr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_q_pop    (w_q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (w_result)
    );

    // Port outputs.
    assign full             = w_q_status.full;
    assign o_corner_a       = w_result.corner_a;
    assign o_corner_b       = w_result.corner_b;
    assign o_corner_c       = w_result.corner_c;
    assign o_triangle_valid = w_result.tri_valid;
    assign o_draw_done      = w_result.done;

endmodule
